@@ rtl/afpc_pkg.sv @@
// Shared types, widths and codes for the altitude flight phase controller.
package afpc_pkg;

  localparam int ALT_W      = 24;
  localparam int THR_W      = 23;
  localparam int RATIO_W    = 8;
  localparam int PHASE_W    = 3;
  localparam int EVT_W      = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int GROUP_SIZE_DEF = 5;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FORCE  = 1'b1;

  localparam logic [PHASE_W-1:0] PH_PRELAUNCH = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LAUNCH    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_APOGEE    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CHUTE     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASE   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_LANDED    = 3'd5;

  localparam logic [EVT_W-1:0] EVT_NONE    = 3'd0;
  localparam logic [EVT_W-1:0] EVT_LAUNCH  = 3'd1;
  localparam logic [EVT_W-1:0] EVT_APOGEE  = 3'd2;
  localparam logic [EVT_W-1:0] EVT_CHUTE   = 3'd3;
  localparam logic [EVT_W-1:0] EVT_RELEASE = 3'd4;
  localparam logic [EVT_W-1:0] EVT_LANDED  = 3'd5;

  localparam logic [CFG_ADDR_W-1:0] REG_LAUNCH_THR   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_LIMIT   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DESCENT_DROP = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CHUTE_RATIO  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_REL_RATIO    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CHUTE_FB     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_REL_FB       = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_LAND_THR     = 3'd7;

  localparam logic [THR_W-1:0]         RST_LAUNCH_THR   = 23'd3000;
  localparam logic [THR_W-1:0]         RST_HIGH_LIMIT   = 23'd10000;
  localparam logic [THR_W-1:0]         RST_DESCENT_DROP = 23'd1000;
  localparam logic [RATIO_W-1:0]       RST_CHUTE_RATIO  = 8'd154;
  localparam logic [RATIO_W-1:0]       RST_REL_RATIO    = 8'd115;
  localparam logic [THR_W-1:0]         RST_CHUTE_FB     = 23'd7000;
  localparam logic [THR_W-1:0]         RST_REL_FB       = 23'd5000;
  localparam logic signed [ALT_W-1:0]  RST_LAND_THR     = 24'sd500;

  localparam logic signed [ALT_W-1:0] PEAK_RST = {1'b1, {(ALT_W-1){1'b0}}};

  typedef struct packed {
    logic                     kind;
    logic signed [ALT_W-1:0]  altitude;
    logic [PHASE_W-1:0]       forced_phase;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0]       phase;
    logic [EVT_W-1:0]         event_res;
    logic                     decided;
    logic signed [ALT_W-1:0]  chosen_altitude;
    logic signed [ALT_W-1:0]  peak_altitude;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0]         launch_threshold;
    logic [THR_W-1:0]         high_altitude_limit;
    logic [THR_W-1:0]         descent_drop;
    logic [RATIO_W-1:0]       chute_ratio;
    logic [RATIO_W-1:0]       release_ratio;
    logic [THR_W-1:0]         chute_fallback;
    logic [THR_W-1:0]         release_fallback;
    logic signed [ALT_W-1:0]  land_threshold;
  } cfg_t;

  typedef struct packed {
    logic                     decided;
    logic signed [ALT_W-1:0]  chosen;
  } grp_res_t;

  typedef struct packed {
    logic [PHASE_W-1:0]       phase;
    logic [EVT_W-1:0]         event_res;
    logic signed [ALT_W-1:0]  peak;
  } ph_res_t;

endpackage

@@ rtl/afpc_if.sv @@
// Valid/ready channel interfaces for input items, results and configuration writes.
interface afpc_in_if import afpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [ALT_W-1:0]  altitude;
  logic [PHASE_W-1:0]       forced_phase;

  modport source (output valid, output kind, output altitude, output forced_phase,
                  input ready);
  modport sink   (input valid, input kind, input altitude, input forced_phase,
                  output ready);
endinterface

interface afpc_out_if import afpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PHASE_W-1:0]       phase;
  logic [EVT_W-1:0]         event_res;
  logic                     decided;
  logic signed [ALT_W-1:0]  chosen_altitude;
  logic signed [ALT_W-1:0]  peak_altitude;

  modport source (output valid, output phase, output event_res, output decided,
                  output chosen_altitude, output peak_altitude, input ready);
  modport sink   (input valid, input phase, input event_res, input decided,
                  input chosen_altitude, input peak_altitude, output ready);
endinterface

interface afpc_cfg_if import afpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_ADDR_W-1:0]    addr;
  logic [CFG_DATA_W-1:0]    data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ rtl/afpc_cfg_regs.sv @@
// Configuration register file with reset values.
module afpc_cfg_regs import afpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   we,
  input  logic [CFG_ADDR_W-1:0]  addr,
  input  logic [CFG_DATA_W-1:0]  data,
  output cfg_t                   cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (addr)
        REG_LAUNCH_THR:   cfg_nxt.launch_threshold    = data[THR_W-1:0];
        REG_HIGH_LIMIT:   cfg_nxt.high_altitude_limit = data[THR_W-1:0];
        REG_DESCENT_DROP: cfg_nxt.descent_drop        = data[THR_W-1:0];
        REG_CHUTE_RATIO:  cfg_nxt.chute_ratio         = data[RATIO_W-1:0];
        REG_REL_RATIO:    cfg_nxt.release_ratio       = data[RATIO_W-1:0];
        REG_CHUTE_FB:     cfg_nxt.chute_fallback      = data[THR_W-1:0];
        REG_REL_FB:       cfg_nxt.release_fallback    = data[THR_W-1:0];
        REG_LAND_THR:     cfg_nxt.land_threshold      = $signed(data[ALT_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.launch_threshold    <= RST_LAUNCH_THR;
      cfg_r.high_altitude_limit <= RST_HIGH_LIMIT;
      cfg_r.descent_drop        <= RST_DESCENT_DROP;
      cfg_r.chute_ratio         <= RST_CHUTE_RATIO;
      cfg_r.release_ratio       <= RST_REL_RATIO;
      cfg_r.chute_fallback      <= RST_CHUTE_FB;
      cfg_r.release_fallback    <= RST_REL_FB;
      cfg_r.land_threshold      <= RST_LAND_THR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/afpc_group.sv @@
// Sample group store, running sum and nearest-to-mean selection.
module afpc_group import afpc_pkg::*; #(
  parameter int GROUP_SIZE = GROUP_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     smp,
  input  logic signed [ALT_W-1:0]  alt,
  output grp_res_t                 res
);

  localparam int FILL_W = $clog2(GROUP_SIZE + 1);
  localparam int IDX_W  = $clog2(GROUP_SIZE);
  localparam int SUM_W  = ALT_W + $clog2(GROUP_SIZE);
  localparam int DIF_W  = SUM_W + 1;

  logic signed [ALT_W-1:0]  samples_r [GROUP_SIZE];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [FILL_W-1:0]        fill_r;
  logic [FILL_W-1:0]        fill_nxt;
  logic                     full;
  logic [IDX_W-1:0]         wr_idx;
  logic signed [DIF_W-1:0]  dif [GROUP_SIZE];
  logic [DIF_W-1:0]         mag [GROUP_SIZE];
  logic [DIF_W-1:0]         best;
  logic signed [ALT_W-1:0]  pick;

  assign full = (fill_r >= FILL_W'(GROUP_SIZE));

  always_comb begin
    for (int i = 0; i < GROUP_SIZE; i++) begin
      dif[i] = DIF_W'(GROUP_SIZE) * DIF_W'(samples_r[i]) - DIF_W'(sum_r);
      mag[i] = dif[i][DIF_W-1] ? DIF_W'(-dif[i]) : DIF_W'(dif[i]);
    end
    best = mag[0];
    pick = samples_r[0];
    for (int i = 1; i < GROUP_SIZE; i++) begin
      if (mag[i] < best) begin
        best = mag[i];
        pick = samples_r[i];
      end
    end
  end

  assign res.decided = smp && full;
  assign res.chosen  = (smp && full) ? pick : '0;

  assign wr_idx   = full ? '0 : fill_r[IDX_W-1:0];
  assign fill_nxt = full ? FILL_W'(1) : fill_r + FILL_W'(1);
  assign sum_nxt  = full ? SUM_W'(alt) : sum_r + SUM_W'(alt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
    end else if (adv && smp) begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && smp) begin
      samples_r[wr_idx] <= alt;
    end
  end

endmodule

@@ rtl/afpc_phase.sv @@
// Peak tracker and flight phase transition logic.
module afpc_phase import afpc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     kind,
  input  logic [PHASE_W-1:0]       forced_phase,
  input  logic signed [ALT_W-1:0]  alt,
  input  grp_res_t                 grp,
  input  cfg_t                     cfg,
  output ph_res_t                  res
);

  localparam int THR_X_W = THR_W + 2;
  localparam int PROD_W  = ALT_W + RATIO_W + 1;
  localparam int DROP_W  = ALT_W + 2;

  logic [PHASE_W-1:0]         phase_r;
  logic [PHASE_W-1:0]         phase_nxt;
  logic signed [ALT_W-1:0]    peak_r;
  logic signed [ALT_W-1:0]    peak_nxt;
  logic [EVT_W-1:0]           evt;
  logic [RATIO_W-1:0]         ratio;
  logic [THR_W-1:0]           fallback;
  logic                       ratio_hi;
  logic signed [PROD_W-1:0]   prod;
  logic signed [THR_X_W-1:0]  thr;
  logic signed [THR_X_W-1:0]  chosen_x;
  logic signed [DROP_W-1:0]   drop;

  assign peak_nxt = (kind == KIND_SAMPLE && alt >= peak_r) ? alt : peak_r;

  assign ratio    = (phase_r == PH_APOGEE) ? cfg.chute_ratio : cfg.release_ratio;
  assign fallback = (phase_r == PH_APOGEE) ? cfg.chute_fallback : cfg.release_fallback;
  assign ratio_hi = THR_X_W'(peak_nxt) > $signed({2'b00, cfg.high_altitude_limit});
  assign prod     = PROD_W'(peak_nxt) * $signed({1'b0, ratio});
  assign thr      = ratio_hi ? THR_X_W'(prod >>> RATIO_W) : $signed({2'b00, fallback});
  assign chosen_x = THR_X_W'(grp.chosen);
  assign drop     = DROP_W'(peak_nxt) - DROP_W'(grp.chosen);

  always_comb begin
    phase_nxt = phase_r;
    evt       = EVT_NONE;
    if (kind == KIND_FORCE) begin
      phase_nxt = forced_phase;
    end else if (grp.decided) begin
      case (phase_r)
        PH_PRELAUNCH: begin
          if (chosen_x > $signed({2'b00, cfg.launch_threshold})) begin
            phase_nxt = PH_LAUNCH;
            evt       = EVT_LAUNCH;
          end
        end
        PH_LAUNCH: begin
          if (chosen_x >= $signed({2'b00, cfg.high_altitude_limit}) ||
              drop >= $signed({3'b000, cfg.descent_drop})) begin
            phase_nxt = PH_APOGEE;
            evt       = EVT_APOGEE;
          end
        end
        PH_APOGEE: begin
          if (chosen_x <= thr) begin
            phase_nxt = PH_CHUTE;
            evt       = EVT_CHUTE;
          end
        end
        PH_CHUTE: begin
          if (chosen_x <= thr) begin
            phase_nxt = PH_RELEASE;
            evt       = EVT_RELEASE;
          end
        end
        PH_RELEASE: begin
          if (grp.chosen <= cfg.land_threshold) begin
            phase_nxt = PH_LANDED;
            evt       = EVT_LANDED;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRELAUNCH;
      peak_r  <= PEAK_RST;
    end else if (adv) begin
      phase_r <= phase_nxt;
      peak_r  <= peak_nxt;
    end
  end

  assign res.phase     = phase_nxt;
  assign res.event_res = evt;
  assign res.peak      = peak_nxt;

endmodule

@@ rtl/altitude_flight_phase_controller.sv @@
// Each item passes the input register and then the result register, and a stall
// on out_ch can hold it in either. Throughput: one item per cycle unless out_ch
// stalls; the input register and the result register each hold one item, and all
// group and phase logic sits between them.
// Reset (rst_n low, synchronous): phase prelaunch, peak most negative, group
// empty, registers at their defaults, both channel stages empty.
module altitude_flight_phase_controller import afpc_pkg::*; #(
  parameter int GROUP_SIZE = GROUP_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  afpc_in_if.sink      in_ch,
  afpc_out_if.source   out_ch,
  afpc_cfg_if.sink     cfg_ch
);

  logic       in_vld_r;
  in_item_t   in_q_r;
  logic       out_vld_r;
  out_item_t  out_q_r;
  out_item_t  out_nxt;
  logic       adv;
  logic       in_rdy;
  cfg_t       cfg;
  grp_res_t   grp_res;
  ph_res_t    ph_res;

  assign adv    = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_rdy = !in_vld_r || adv;

  assign in_ch.ready  = in_rdy;
  assign cfg_ch.ready = 1'b1;

  afpc_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_ch.valid),
    .addr  (cfg_ch.addr),
    .data  (cfg_ch.data),
    .cfg   (cfg)
  );

  afpc_group #(.GROUP_SIZE(GROUP_SIZE)) u_group (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .smp   (in_q_r.kind == KIND_SAMPLE),
    .alt   (in_q_r.altitude),
    .res   (grp_res)
  );

  afpc_phase u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .kind         (in_q_r.kind),
    .forced_phase (in_q_r.forced_phase),
    .alt          (in_q_r.altitude),
    .grp          (grp_res),
    .cfg          (cfg),
    .res          (ph_res)
  );

  always_comb begin
    out_nxt.phase           = ph_res.phase;
    out_nxt.event_res       = ph_res.event_res;
    out_nxt.decided         = grp_res.decided;
    out_nxt.chosen_altitude = grp_res.chosen;
    out_nxt.peak_altitude   = ph_res.peak;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_vld_r <= in_ch.valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_rdy) begin
      in_q_r.kind         <= in_ch.kind;
      in_q_r.altitude     <= in_ch.altitude;
      in_q_r.forced_phase <= in_ch.forced_phase;
    end
    if (adv) begin
      out_q_r <= out_nxt;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.phase           = out_q_r.phase;
  assign out_ch.event_res       = out_q_r.event_res;
  assign out_ch.decided         = out_q_r.decided;
  assign out_ch.chosen_altitude = out_q_r.chosen_altitude;
  assign out_ch.peak_altitude   = out_q_r.peak_altitude;

`ifndef ASSERT_OFF
  a_force_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_q_r.kind == KIND_FORCE |=>
      out_q_r.event_res == EVT_NONE && !out_q_r.decided)
    else $error("force item produced an event or a decision");

  a_event_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_q_r.event_res != EVT_NONE |->
      out_q_r.decided && out_q_r.phase == out_q_r.event_res)
    else $error("event code does not match the new phase");

  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_q_r.kind == KIND_SAMPLE |-> ph_res.peak >= in_q_r.altitude)
    else $error("peak below the current sample");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the flight phase controller: scripted and random flights vs a predictor.
module tb import afpc_pkg::*; ();

  localparam int GROUP_N         = GROUP_SIZE_DEF;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 6;
  localparam int ITEMS_PER_PHASE = 270;
  localparam int NUM_CFG_PHASES  = 6;

  localparam longint ALT_MAX = 64'sd8388607;
  localparam longint ALT_MIN = -64'sd8388608;

  localparam logic [PHASE_W-1:0] PH_IDLE_A = 3'd6;
  localparam logic [PHASE_W-1:0] PH_IDLE_B = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  afpc_in_if  in_ch ();
  afpc_out_if out_ch ();
  afpc_cfg_if cfg_ch ();

  altitude_flight_phase_controller #(.GROUP_SIZE(GROUP_N)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  in_item_t  cur_item;
  out_item_t want_res;

  int n_queued  = 0;
  int n_sent    = 0;
  int n_errors  = 0;
  int send_idle = 7;
  int recv_idle = 52;

  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;

  cfg_t                    model_cfg;
  logic [PHASE_W-1:0]      model_phase;
  logic signed [ALT_W-1:0] model_peak;
  logic signed [ALT_W-1:0] group_buf [GROUP_N];
  longint                  group_total;
  int                      group_count;

  function automatic void reset_model();
    model_cfg.launch_threshold    = RST_LAUNCH_THR;
    model_cfg.high_altitude_limit = RST_HIGH_LIMIT;
    model_cfg.descent_drop        = RST_DESCENT_DROP;
    model_cfg.chute_ratio         = RST_CHUTE_RATIO;
    model_cfg.release_ratio       = RST_REL_RATIO;
    model_cfg.chute_fallback      = RST_CHUTE_FB;
    model_cfg.release_fallback    = RST_REL_FB;
    model_cfg.land_threshold      = RST_LAND_THR;
    model_phase = PH_PRELAUNCH;
    model_peak  = PEAK_RST;
    group_total = 0;
    group_count = 0;
  endfunction

  function automatic longint descent_limit(logic [RATIO_W-1:0] ratio,
                                           logic [THR_W-1:0] fallback);
    longint pk;
    longint hi;
    pk = model_peak;
    hi = longint'(model_cfg.high_altitude_limit);
    if (pk > hi) begin
      return (pk * longint'(ratio)) / 256;
    end
    return longint'(fallback);
  endfunction

  function automatic out_item_t predict_step(in_item_t it);
    out_item_t               res;
    logic signed [ALT_W-1:0] a24;
    longint                  alt;
    longint                  pk;
    longint                  best;
    longint                  gap;
    longint                  pick;
    logic [EVT_W-1:0]        evt;
    logic                    dec;
    int                      i;
    evt  = EVT_NONE;
    dec  = 1'b0;
    pick = 0;
    if (it.kind == KIND_FORCE) begin
      model_phase = it.forced_phase;
    end else begin
      a24 = it.altitude;
      alt = a24;
      if (a24 >= model_peak) begin
        model_peak = a24;
      end
      pk = model_peak;
      if (group_count >= GROUP_N) begin
        best = -1;
        for (i = 0; i < GROUP_N; i++) begin
          gap = longint'(GROUP_N) * longint'(group_buf[i]) - group_total;
          if (gap < 0) begin
            gap = -gap;
          end
          if (best < 0 || gap < best) begin
            best = gap;
            pick = group_buf[i];
          end
        end
        group_count = 0;
        group_total = 0;
        dec = 1'b1;
        case (model_phase)
          PH_PRELAUNCH: begin
            if (pick > longint'(model_cfg.launch_threshold)) begin
              model_phase = PH_LAUNCH;
              evt = EVT_LAUNCH;
            end
          end
          PH_LAUNCH: begin
            if (pick >= longint'(model_cfg.high_altitude_limit) ||
                pk - pick >= longint'(model_cfg.descent_drop)) begin
              model_phase = PH_APOGEE;
              evt = EVT_APOGEE;
            end
          end
          PH_APOGEE: begin
            if (pick <= descent_limit(model_cfg.chute_ratio, model_cfg.chute_fallback)) begin
              model_phase = PH_CHUTE;
              evt = EVT_CHUTE;
            end
          end
          PH_CHUTE: begin
            if (pick <= descent_limit(model_cfg.release_ratio,
                                      model_cfg.release_fallback)) begin
              model_phase = PH_RELEASE;
              evt = EVT_RELEASE;
            end
          end
          PH_RELEASE: begin
            if (pick <= longint'(model_cfg.land_threshold)) begin
              model_phase = PH_LANDED;
              evt = EVT_LANDED;
            end
          end
          default: begin
          end
        endcase
      end
      group_buf[group_count] = a24;
      group_count++;
      group_total += alt;
    end
    res.phase           = model_phase;
    res.event_res       = evt;
    res.decided         = dec;
    res.chosen_altitude = pick[ALT_W-1:0];
    res.peak_altitude   = model_peak;
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", field, got, want);
    n_errors++;
  endtask

  function automatic longint rnd(longint lo, longint hi);
    return lo + longint'($urandom_range(int'(hi - lo), 0));
  endfunction

  function automatic logic signed [ALT_W-1:0] clip_alt(longint v);
    if (v > ALT_MAX) begin
      v = ALT_MAX;
    end else if (v < ALT_MIN) begin
      v = ALT_MIN;
    end
    return v[ALT_W-1:0];
  endfunction

  task automatic push_item(logic kind, logic signed [ALT_W-1:0] alt, logic [PHASE_W-1:0] fp);
    in_item_t it;
    it.kind         = kind;
    it.altitude     = alt;
    it.forced_phase = fp;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic push_sample(longint v);
    push_item(KIND_SAMPLE, clip_alt(v), PHASE_W'(rnd(0, 7)));
  endtask

  task automatic push_noise();
    if (rnd(0, 1) == 1) begin
      push_item(KIND_FORCE, clip_alt(rnd(ALT_MIN, ALT_MAX)), PHASE_W'(rnd(0, 7)));
    end else begin
      push_sample(rnd(ALT_MIN, ALT_MAX));
    end
  endtask

  task automatic push_group(longint level, longint spread);
    repeat (GROUP_N) begin
      if (rnd(0, 99) < 4) begin
        push_noise();
      end else begin
        push_sample(level + rnd(-spread, spread));
      end
    end
  endtask

  task automatic gen_flight();
    longint lt;
    longint hi;
    longint land;
    longint apex;
    longint lvl;
    int     ng;
    int     steps;
    int     i;
    lt   = longint'(model_cfg.launch_threshold);
    hi   = longint'(model_cfg.high_altitude_limit);
    land = longint'(model_cfg.land_threshold);
    push_item(KIND_FORCE, clip_alt(rnd(ALT_MIN, ALT_MAX)), PH_PRELAUNCH);
    repeat (rnd(1, 2)) push_group(lt - rnd(0, 3000), rnd(0, 200));
    apex = ((hi > lt) ? hi : lt) + rnd(1, 40000);
    ng = int'(rnd(2, 4));
    for (i = 1; i <= ng; i++) begin
      push_group(lt + (apex - lt) * i / ng, rnd(0, 500));
    end
    lvl   = apex;
    steps = 0;
    while (lvl > land && steps < 30) begin
      lvl = lvl - (lvl - land) * rnd(10, 40) / 100 - rnd(100, 2000);
      push_group(lvl, rnd(0, 300));
      steps++;
    end
    repeat (rnd(1, 2)) push_group(land - rnd(0, 1000), rnd(0, 100));
    if (rnd(0, 3) == 0) begin
      push_item(KIND_FORCE, clip_alt(rnd(ALT_MIN, ALT_MAX)),
                (rnd(0, 1) == 1) ? PH_IDLE_A : PH_IDLE_B);
    end
  endtask

  task automatic run_directed();
    longint flight_alt [26];
    flight_alt = '{5000, 6000, 4000, 8500, 4000,
                   7000, 6000, 5000, 9500, 5000,
                   6900, 6800, 6700, 6800, 6800,
                   4800, 4900, 5000, 4700, 4600,
                   ALT_MIN, ALT_MIN, 0, 400, ALT_MAX,
                   ALT_MIN};
    foreach (flight_alt[k]) push_sample(flight_alt[k]);
    push_item(KIND_FORCE, clip_alt(ALT_MAX), PH_IDLE_A);
    push_item(KIND_FORCE, clip_alt(ALT_MIN), PH_IDLE_B);
    push_item(KIND_FORCE, '0, PH_LANDED);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_LAUNCH_THR:   model_cfg.launch_threshold    = value[THR_W-1:0];
      REG_HIGH_LIMIT:   model_cfg.high_altitude_limit = value[THR_W-1:0];
      REG_DESCENT_DROP: model_cfg.descent_drop        = value[THR_W-1:0];
      REG_CHUTE_RATIO:  model_cfg.chute_ratio         = value[RATIO_W-1:0];
      REG_REL_RATIO:    model_cfg.release_ratio       = value[RATIO_W-1:0];
      REG_CHUTE_FB:     model_cfg.chute_fallback      = value[THR_W-1:0];
      REG_REL_FB:       model_cfg.release_fallback    = value[THR_W-1:0];
      REG_LAND_THR:     model_cfg.land_threshold      = $signed(value[ALT_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(REG_LAUNCH_THR,   CFG_DATA_W'(c.launch_threshold));
    write_reg(REG_HIGH_LIMIT,   CFG_DATA_W'(c.high_altitude_limit));
    write_reg(REG_DESCENT_DROP, CFG_DATA_W'(c.descent_drop));
    write_reg(REG_CHUTE_RATIO,  CFG_DATA_W'(c.chute_ratio));
    write_reg(REG_REL_RATIO,    CFG_DATA_W'(c.release_ratio));
    write_reg(REG_CHUTE_FB,     CFG_DATA_W'(c.chute_fallback));
    write_reg(REG_REL_FB,       CFG_DATA_W'(c.release_fallback));
    write_reg(REG_LAND_THR,     c.land_threshold);
  endtask

  function automatic cfg_t pick_config(int ph);
    cfg_t c;
    case (ph)
      0: begin
        c.launch_threshold    = RST_LAUNCH_THR;
        c.high_altitude_limit = RST_HIGH_LIMIT;
        c.descent_drop        = RST_DESCENT_DROP;
        c.chute_ratio         = RST_CHUTE_RATIO;
        c.release_ratio       = RST_REL_RATIO;
        c.chute_fallback      = RST_CHUTE_FB;
        c.release_fallback    = RST_REL_FB;
        c.land_threshold      = RST_LAND_THR;
      end
      1: begin
        c = '0;
        c.land_threshold = PEAK_RST;
      end
      4: begin
        c = '1;
        c.land_threshold = clip_alt(ALT_MAX);
      end
      default: begin
        c.launch_threshold    = THR_W'(rnd(0, 20000));
        c.high_altitude_limit = (rnd(0, 2) == 0) ? '1 : THR_W'(rnd(0, 200000));
        c.descent_drop        = THR_W'(rnd(0, 50000));
        c.chute_ratio         = RATIO_W'(rnd(0, 255));
        c.release_ratio       = RATIO_W'(rnd(0, 255));
        c.chute_fallback      = THR_W'(rnd(0, 200000));
        c.release_fallback    = THR_W'(rnd(0, 200000));
        c.land_threshold      = clip_alt(rnd(-20000, 20000));
      end
    endcase
    return c;
  endfunction

  task automatic wait_drained();
    while (n_sent != n_queued || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.kind         <= KIND_SAMPLE;
      in_ch.altitude     <= '0;
      in_ch.forced_phase <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_step(cur_item));
        n_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_item = pending_items.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.kind         <= cur_item.kind;
          in_ch.altitude     <= cur_item.altitude;
          in_ch.forced_phase <= cur_item.forced_phase;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want_res = expected_results.pop_front();
        if (out_ch.phase !== want_res.phase)
          report_mismatch("phase", longint'(out_ch.phase), longint'(want_res.phase));
        if (out_ch.event_res !== want_res.event_res)
          report_mismatch("event_res", longint'(out_ch.event_res),
                          longint'(want_res.event_res));
        if (out_ch.decided !== want_res.decided)
          report_mismatch("decided", longint'(out_ch.decided), longint'(want_res.decided));
        if (out_ch.chosen_altitude !== want_res.chosen_altitude)
          report_mismatch("chosen_altitude", longint'(out_ch.chosen_altitude),
                          longint'(want_res.chosen_altitude));
        if (out_ch.peak_altitude !== want_res.peak_altitude)
          report_mismatch("peak_altitude", longint'(out_ch.peak_altitude),
                          longint'(want_res.peak_altitude));
      end
    end
    out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int ph;
    int target;
    cfg_ch.valid       = 1'b0;
    cfg_ch.addr        = '0;
    cfg_ch.data        = '0;
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    wait_drained();
    for (ph = 0; ph < NUM_CFG_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle = 7;
        recv_idle = 52;
      end else if (ph < 4) begin
        send_idle = 52;
        recv_idle = 7;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      apply_config(pick_config(ph));
      target = n_queued + ITEMS_PER_PHASE;
      while (n_queued < target) gen_flight();
      // stall the result side while items keep coming
      if (ph == 4) hold_toggle = ~hold_toggle;
      wait_drained();
    end
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
